// File: design/csrd_pkg.sv
`default_nettype none

package csrd_pkg;

   // Character class codes
   localparam logic [1:0] CLASS_LOWER = 2'd0;
   localparam logic [1:0] CLASS_UPPER = 2'd1;
   localparam logic [1:0] CLASS_DIGIT = 2'd2;
   localparam logic [1:0] CLASS_OTHER = 2'd3;

   localparam logic [4:0] SPACE_ALPHA = 5'd26;
   localparam logic [4:0] SPACE_DIGIT = 5'd10;

   localparam logic [6:0] MAX_STEP_RESET = 7'd5;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] ch;
      logic       last_char;
   } req_word_type;

   typedef struct packed {
      logic [7:0]        start_index;
      logic [7:0]        end_index;
      logic [1:0]        seq_class;
      logic [4:0]        class_space;
      logic              ascending;
      logic signed [7:0] step;
      logic              last_of_item;
      logic              ends_password;
   } rsp_word_type;

   // Up to two reports per byte; a single report always sits in first.
   typedef struct packed {
      logic         two;
      rsp_word_type first;
      rsp_word_type second;
   } entry_type;

endpackage

`default_nettype wire

// File: design/constant_step_run_detector.sv
`default_nettype none

// Channel   Dir  Handshake             Word
// req_      in   req_push / req_full   req_word_type  (ch, last_char)
// rsp_      out  rsp_pop / rsp_empty   rsp_word_type  (one run report)
// csr_      in   csr_valid / csr_ready 7-bit max_step
//
// One byte is taken every cycle while req_full is low; the front updates run
// state and pushes that byte's reports, if it has any (one or two), as one
// entry into a 4-entry queue. The back hands out one report per cycle while
// rsp_pop is high; a byte with two reports holds the result side for two pops.
// req_full rises only when the queue is full, i.e. the result side has stalled.
// Synchronous active-high reset; max_step returns to 5. No clearing pass.
module constant_step_run_detector
   import csrd_pkg::*;
#(
   parameter int MAX_LEN = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // byte input
   input  wire logic         req_push,
   input  wire req_word_type req_data,
   output logic              req_full,
   // report output
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output rsp_word_type      rsp_data,
   // max_step register
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [6:0]   csr_wdata
);

   logic      q_full;
   logic      q_not_empty;
   logic      q_enq;
   logic      q_deq;
   entry_type q_enq_entry;
   entry_type q_head;

   // register is always writable; the user must write it only while idle (not enforced here)
   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   csrd_front #(
      .MAX_LEN(MAX_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .item      (req_data),
      .queue_full(q_full),
      .csr_write (csr_valid),
      .csr_value (csr_wdata),
      .enq       (q_enq),
      .enq_entry (q_enq_entry)
   );

   // decouples byte intake from report delivery
   csrd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (q_enq),
      .enq_entry(q_enq_entry),
      .full     (q_full),
      .deq      (q_deq),
      .not_empty(q_not_empty),
      .head     (q_head)
   );

   csrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_not_empty(q_not_empty),
      .q_head     (q_head),
      .q_deq      (q_deq),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// File: design/csrd_queue.sv
`default_nettype none

module csrd_queue
   import csrd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      enq,
   input  wire entry_type enq_entry,
   output logic           full,
   input  wire logic      deq,
   output logic           not_empty,
   output entry_type      head
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_enq, do_deq;

   assign full      = (count_ff == CntW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_enq    = enq & ~full;
   assign do_deq    = deq & not_empty;

   always_comb begin
      wr_ptr_in = do_enq ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_deq ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq && !do_deq) begin
         count_in = count_ff + CntW'(1);
      end else if (!do_enq && do_deq) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         mem_ff[wr_ptr_ff] <= enq_entry;
      end
   end

endmodule

`default_nettype wire

// File: design/csrd_front.sv
`default_nettype none

module csrd_front
   import csrd_pkg::*;
#(
   parameter int MAX_LEN = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire req_word_type item,
   input  wire logic         queue_full,
   input  wire logic         csr_write,
   input  wire logic [6:0]   csr_value,
   output logic              enq,
   output entry_type         enq_entry
);

   localparam int PosW = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
   localparam logic [PosW-1:0] PosMax = PosW'(MAX_LEN - 1);

   logic [6:0]          max_step_ff, max_step_in;
   logic [7:0]          prev_byte_ff, prev_byte_in;
   logic                have_prev_ff, have_prev_in;
   logic                have_step_ff, have_step_in;
   logic signed [8:0]   run_step_ff, run_step_in;
   logic [PosW-1:0]     run_begin_ff, run_begin_in;
   logic [PosW-1:0]     position_ff, position_in;
   logic                all_lower_ff, all_lower_in;
   logic                all_upper_ff, all_upper_in;
   logic                all_digit_ff, all_digit_in;

   logic                accept;
   logic [7:0]          c;
   logic                last;
   logic signed [8:0]   diff;
   logic signed [8:0]   step_eff;
   logic [PosW-1:0]     cur;
   logic                same;
   logic                c_lower, c_upper, c_digit;
   logic                p_lower, p_upper, p_digit;
   logic                new_lower, new_upper, new_digit;
   logic                close_a, close_b;
   rsp_word_type        word_a, word_b;

   function automatic logic is_lower(input logic [7:0] x);
      return (x >= 8'h61) && (x <= 8'h7a);
   endfunction

   function automatic logic is_upper(input logic [7:0] x);
      return (x >= 8'h41) && (x <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] x);
      return (x >= 8'h30) && (x <= 8'h39);
   endfunction

   function automatic logic [7:0] to_idx(input logic [PosW-1:0] p);
      logic [PosW+7:0] e;
      e = {8'd0, p};
      return e[7:0];
   endfunction

   // Run qualifies: nonzero step within limit, and longer than two chars or unit step.
   function automatic logic qualifies(input logic [PosW-1:0] i, input logic [PosW-1:0] j,
                                      input logic signed [8:0] d, input logic [6:0] lim);
      logic [8:0] mag;
      logic       long_run;
      mag      = d[8] ? 9'(-d) : 9'(d);
      long_run = (j - i) > PosW'(1);
      return (long_run || (mag == 9'd1)) && (mag != 9'd0) && (mag <= {2'b00, lim});
   endfunction

   function automatic rsp_word_type make_word(input logic [PosW-1:0] i,
                                              input logic [PosW-1:0] j,
                                              input logic signed [8:0] d,
                                              input logic lo, input logic up,
                                              input logic dg, input logic ends);
      rsp_word_type w;
      w.start_index = to_idx(i);
      w.end_index   = to_idx(j);
      if (lo) begin
         w.seq_class   = CLASS_LOWER;
         w.class_space = SPACE_ALPHA;
      end else if (up) begin
         w.seq_class   = CLASS_UPPER;
         w.class_space = SPACE_ALPHA;
      end else if (dg) begin
         w.seq_class   = CLASS_DIGIT;
         w.class_space = SPACE_DIGIT;
      end else begin
         w.seq_class   = CLASS_OTHER;
         w.class_space = SPACE_ALPHA;
      end
      w.ascending     = ~d[8] && (d != 9'sd0);
      w.step          = d[7:0];
      w.last_of_item  = 1'b0;
      w.ends_password = ends;
      return w;
   endfunction

   assign accept = push & ~queue_full;
   assign c      = item.ch;
   assign last   = item.last_char;

   always_comb begin
      c_lower   = is_lower(c);
      c_upper   = is_upper(c);
      c_digit   = is_digit(c);
      p_lower   = is_lower(prev_byte_ff);
      p_upper   = is_upper(prev_byte_ff);
      p_digit   = is_digit(prev_byte_ff);
      diff      = $signed({c[7], c}) - $signed({prev_byte_ff[7], prev_byte_ff});
      cur       = (position_ff == PosMax) ? position_ff : position_ff + PosW'(1);
      step_eff  = have_step_ff ? run_step_ff : diff;
      same      = (diff == step_eff);

      if (same) begin
         new_lower    = all_lower_ff & c_lower;
         new_upper    = all_upper_ff & c_upper;
         new_digit    = all_digit_ff & c_digit;
         run_begin_in = run_begin_ff;
      end else begin
         new_lower    = p_lower & c_lower;
         new_upper    = p_upper & c_upper;
         new_digit    = p_digit & c_digit;
         run_begin_in = position_ff;
      end

      // close of the previous run on a step change
      close_a = have_prev_ff & ~same &
                qualifies(run_begin_ff, position_ff, step_eff, max_step_ff);
      word_a  = make_word(run_begin_ff, position_ff, step_eff,
                          all_lower_ff, all_upper_ff, all_digit_ff, last);
      // close of the open run at end of password
      close_b = have_prev_ff & last &
                qualifies(run_begin_in, cur, diff, max_step_ff);
      word_b  = make_word(run_begin_in, cur, diff, new_lower, new_upper, new_digit, 1'b1);

      enq_entry.two    = close_a & close_b;
      enq_entry.first  = close_a ? word_a : word_b;
      enq_entry.second = word_b;
      enq_entry.first.last_of_item  = ~(close_a & close_b);
      enq_entry.second.last_of_item = 1'b1;
      enq = accept & (close_a | close_b);

      max_step_in  = csr_write ? csr_value : max_step_ff;
      prev_byte_in = prev_byte_ff;
      have_prev_in = have_prev_ff;
      have_step_in = have_step_ff;
      run_step_in  = run_step_ff;
      position_in  = position_ff;
      all_lower_in = all_lower_ff;
      all_upper_in = all_upper_ff;
      all_digit_in = all_digit_ff;

      if (accept) begin
         if (last) begin
            // end of password: back to start state
            prev_byte_in = '0;
            have_prev_in = 1'b0;
            have_step_in = 1'b0;
            run_step_in  = '0;
            run_begin_in = '0;
            position_in  = '0;
            all_lower_in = 1'b1;
            all_upper_in = 1'b1;
            all_digit_in = 1'b1;
         end else if (!have_prev_ff) begin
            prev_byte_in = c;
            have_prev_in = 1'b1;
            run_begin_in = '0;
            position_in  = '0;
            all_lower_in = c_lower;
            all_upper_in = c_upper;
            all_digit_in = c_digit;
         end else begin
            prev_byte_in = c;
            have_step_in = 1'b1;
            run_step_in  = diff;
            position_in  = cur;
            all_lower_in = new_lower;
            all_upper_in = new_upper;
            all_digit_in = new_digit;
         end
      end else begin
         run_begin_in = run_begin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff  <= MAX_STEP_RESET;
         prev_byte_ff <= '0;
         have_prev_ff <= 1'b0;
         have_step_ff <= 1'b0;
         run_step_ff  <= '0;
         run_begin_ff <= '0;
         position_ff  <= '0;
         all_lower_ff <= 1'b1;
         all_upper_ff <= 1'b1;
         all_digit_ff <= 1'b1;
      end else begin
         max_step_ff  <= max_step_in;
         prev_byte_ff <= prev_byte_in;
         have_prev_ff <= have_prev_in;
         have_step_ff <= have_step_in;
         run_step_ff  <= run_step_in;
         run_begin_ff <= run_begin_in;
         position_ff  <= position_in;
         all_lower_ff <= all_lower_in;
         all_upper_ff <= all_upper_in;
         all_digit_ff <= all_digit_in;
      end
   end

endmodule

`default_nettype wire

// File: design/csrd_back.sv
`default_nettype none

module csrd_back
   import csrd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_not_empty,
   input  wire entry_type q_head,
   output logic           q_deq,
   output logic           rsp_empty,
   input  wire logic      rsp_pop,
   output rsp_word_type   rsp_data
);

   entry_type cur_ff, cur_in;
   logic      have_ff, have_in;
   logic      sel_ff, sel_in;
   logic      fire, done;

   assign rsp_empty = ~have_ff;
   assign rsp_data  = sel_ff ? cur_ff.second : cur_ff.first;
   assign fire      = rsp_pop & have_ff;
   assign done      = fire & (sel_ff | ~cur_ff.two);
   assign q_deq     = q_not_empty & (~have_ff | done);

   always_comb begin
      cur_in  = cur_ff;
      have_in = have_ff;
      sel_in  = sel_ff;
      if (q_deq) begin
         cur_in  = q_head;
         have_in = 1'b1;
         sel_in  = 1'b0;
      end else if (done) begin
         have_in = 1'b0;
         sel_in  = 1'b0;
      end else if (fire) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         sel_ff  <= 1'b0;
      end else begin
         have_ff <= have_in;
         sel_ff  <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire
